// ----- hdl/rqts_pkg.sv -----
// Package: shared types and constants of the ready-queue task scheduler.
package rqts_pkg;
	localparam int MaxTasks = 16;
	localparam int TidW = 4;
	localparam int CntW = 5;
	localparam int TimeW = 63;

	localparam logic [2:0] OP_SPAWN = 3'd0;
	localparam logic [2:0] OP_TICK = 3'd1;
	localparam logic [2:0] OP_REPORT = 3'd2;
	localparam logic [2:0] OP_WAKE = 3'd3;
	localparam logic [2:0] OP_WAKE_IO = 3'd4;

	localparam logic [2:0] OC_YIELD = 3'd0;
	localparam logic [2:0] OC_BLOCK = 3'd1;
	localparam logic [2:0] OC_BLOCK_IO = 3'd2;
	localparam logic [2:0] OC_SLEEP = 3'd3;
	localparam logic [2:0] OC_DONE = 3'd4;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READY = 3'd1;
	localparam logic [2:0] ST_RUNNING = 3'd2;
	localparam logic [2:0] ST_BLOCKED = 3'd3;
	localparam logic [2:0] ST_BLOCKED_IO = 3'd4;
	localparam logic [2:0] ST_SLEEPING = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	localparam logic [1:0] RS_OK = 2'd0;
	localparam logic [1:0] RS_IGNORED = 2'd1;
	localparam logic [1:0] RS_FULL = 2'd2;
	localparam logic [1:0] RS_NORUN = 2'd3;

	typedef struct packed {
		logic load;      // latch request, clear woken count
		logic exec;      // perform non-tick op
		logic scan;      // examine next sleep slot
		logic dispatch;  // finish tick
	} rqts_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic is_tick;
	} rqts_stat_t;
endpackage

// ----- hdl/ready_queue_task_scheduler_core.sv -----
// Top level: ready-queue round-robin task scheduler.
// Sequencing: a non-tick request is loaded, executed in the decode state and then presented as a result;
// a tick scans the sleep slots in turn, all 16 of them, then dispatches before presenting the result.
// Throughput: one request at a time; next accepted the cycle after the result is taken.
// Reset: arst_n clears queue pointers, counters, task states and sleep flags.
module ready_queue_task_scheduler_core import rqts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [135:0] s_tdata, // operation, task_id, outcome, current_time, wake_time
	output logic m_tvalid,
	input logic m_tready,
	output logic [23:0] m_tdata // dispatched_task, dispatched_valid, status, ready_total, blocked_total, woken_total
);
	rqts_cmd_t cmd;
	rqts_stat_t stat;
	logic [TidW-1:0] disp_task;
	logic disp_valid;
	logic [1:0] res_status;
	logic [CntW-1:0] rt, bt, wt;

	rqts_ctrl u_ctrl (
		.clk, .arst_n,
		.in_fire(s_tvalid && s_tready),
		.in_ready(s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.stat, .cmd
	);

	rqts_datapath u_dp (
		.clk, .arst_n, .cmd, .stat,
		.op_in(s_tdata[2:0]),
		.tid_in(s_tdata[6:3]),
		.oc_in(s_tdata[9:7]),
		.now_in(s_tdata[72:10]),
		.wake_in(s_tdata[135:73]),
		.disp_task, .disp_valid, .res_status,
		.ready_total(rt), .blocked_total(bt), .woken_total(wt)
	);

	assign m_tdata = {2'b00, wt, bt, rt, res_status, disp_valid, disp_task};
endmodule

// ----- hdl/rqts_datapath.sv -----
// Datapath: ready queue, task table, sleep slots and counters.
module rqts_datapath import rqts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input rqts_cmd_t cmd,
	output rqts_stat_t stat,
	input logic [2:0] op_in,
	input logic [TidW-1:0] tid_in,
	input logic [2:0] oc_in,
	input logic [TimeW-1:0] now_in,
	input logic [TimeW-1:0] wake_in,
	output logic [TidW-1:0] disp_task,
	output logic disp_valid,
	output logic [1:0] res_status,
	output logic [CntW-1:0] ready_total,
	output logic [CntW-1:0] blocked_total,
	output logic [CntW-1:0] woken_total
);
	logic [TidW-1:0] fifo_mem [MaxTasks];
	logic [TimeW-1:0] dl_mem [MaxTasks];
	logic [2:0] tstat_q [MaxTasks];
	logic [MaxTasks-1:0] pend_q;
	logic [TidW-1:0] head_q, tail_q, run_q, tid_q, idx_q;
	logic [CntW-1:0] cnt_q, blk_q, woken_q;
	logic run_v_q;
	logic [2:0] op_q, oc_q;
	logic [TimeW-1:0] now_q, wake_q;

	assign stat.scan_last = (idx_q == TidW'(MaxTasks - 1));
	assign stat.is_tick = (op_q == OP_TICK);
	assign ready_total = cnt_q;
	assign blocked_total = blk_q;
	assign woken_total = woken_q;

	logic full;
	logic [2:0] st_t, st_i;
	logic cnt_t, cnt_i, due;
	assign full = (cnt_q == CntW'(MaxTasks));
	assign st_t = tstat_q[tid_q];
	assign cnt_t = (st_t == ST_BLOCKED_IO) || (st_t == ST_SLEEPING);
	assign st_i = tstat_q[idx_q];
	assign cnt_i = (st_i == ST_BLOCKED_IO) || (st_i == ST_SLEEPING);
	assign due = pend_q[idx_q] && (now_q >= dl_mem[idx_q]);

	always_ff @(posedge clk) begin
		if (cmd.exec && op_q == OP_REPORT && run_v_q && oc_q == OC_SLEEP)
			dl_mem[run_q] <= wake_q;
		if (cmd.load) begin
			op_q <= op_in;
			tid_q <= tid_in;
			oc_q <= oc_in;
			now_q <= now_in;
			wake_q <= wake_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MaxTasks; i++) tstat_q[i] <= ST_IDLE;
			pend_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			cnt_q <= '0;
			blk_q <= '0;
			run_q <= '0;
			run_v_q <= 1'b0;
			idx_q <= '0;
			woken_q <= '0;
			disp_task <= '0;
			disp_valid <= 1'b0;
			res_status <= RS_OK;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
				woken_q <= '0;
				disp_task <= '0;
				disp_valid <= 1'b0;
				res_status <= RS_OK;
			end
			if (cmd.scan) begin
				idx_q <= idx_q + 1'b1;
				if (due) begin
					if (!cnt_i) pend_q[idx_q] <= 1'b0;
					else if (!full) begin
						fifo_mem[tail_q] <= idx_q;
						tail_q <= tail_q + 1'b1;
						cnt_q <= cnt_q + 1'b1;
						tstat_q[idx_q] <= ST_READY;
						if (blk_q != '0) blk_q <= blk_q - 1'b1;
						pend_q[idx_q] <= 1'b0;
						woken_q <= woken_q + 1'b1;
					end
				end
			end
			if (cmd.dispatch && !run_v_q && cnt_q != '0) begin
				run_q <= fifo_mem[head_q];
				run_v_q <= 1'b1;
				tstat_q[fifo_mem[head_q]] <= ST_RUNNING;
				disp_task <= fifo_mem[head_q];
				disp_valid <= 1'b1;
				head_q <= head_q + 1'b1;
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.exec) begin
				unique case (op_q)
					OP_SPAWN: begin
						if (st_t != ST_IDLE && st_t != ST_DONE) res_status <= RS_IGNORED;
						else if (full) res_status <= RS_FULL;
						else begin
							fifo_mem[tail_q] <= tid_q;
							tail_q <= tail_q + 1'b1;
							cnt_q <= cnt_q + 1'b1;
							tstat_q[tid_q] <= ST_READY;
						end
					end
					OP_REPORT: begin
						if (!run_v_q) res_status <= RS_NORUN;
						else begin
							unique case (oc_q)
								OC_YIELD: begin
									if (full) res_status <= RS_FULL;
									else begin
										fifo_mem[tail_q] <= run_q;
										tail_q <= tail_q + 1'b1;
										cnt_q <= cnt_q + 1'b1;
										tstat_q[run_q] <= ST_READY;
										run_v_q <= 1'b0;
									end
								end
								OC_BLOCK: begin
									tstat_q[run_q] <= ST_BLOCKED;
									run_v_q <= 1'b0;
								end
								OC_BLOCK_IO: begin
									tstat_q[run_q] <= ST_BLOCKED_IO;
									if (blk_q != CntW'(MaxTasks)) blk_q <= blk_q + 1'b1;
									run_v_q <= 1'b0;
								end
								OC_SLEEP: begin
									tstat_q[run_q] <= ST_SLEEPING;
									pend_q[run_q] <= 1'b1;
									if (blk_q != CntW'(MaxTasks)) blk_q <= blk_q + 1'b1;
									run_v_q <= 1'b0;
								end
								OC_DONE: begin
									tstat_q[run_q] <= ST_DONE;
									run_v_q <= 1'b0;
								end
								default: res_status <= RS_IGNORED;
							endcase
						end
					end
					OP_WAKE, OP_WAKE_IO: begin
						if (!cnt_t && !(op_q == OP_WAKE && st_t == ST_BLOCKED))
							res_status <= RS_IGNORED;
						else if (full) res_status <= RS_FULL;
						else begin
							fifo_mem[tail_q] <= tid_q;
							tail_q <= tail_q + 1'b1;
							cnt_q <= cnt_q + 1'b1;
							tstat_q[tid_q] <= ST_READY;
							if (cnt_t) begin
								if (blk_q != '0) blk_q <= blk_q - 1'b1;
								pend_q[tid_q] <= 1'b0;
							end
						end
					end
					default: res_status <= RS_IGNORED;
				endcase
			end
		end
	end
endmodule

// ----- hdl/rqts_ctrl.sv -----
// Controller: sequences load, sleep scan, dispatch and result handshake.
module rqts_ctrl import rqts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input rqts_stat_t stat,
	output rqts_cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_DISP = 3'd3;
	localparam logic [2:0] S_OUT = 3'd4;

	logic [2:0] state_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	always_comb begin
		cmd.load = in_fire;
		cmd.exec = (state_q == S_DEC) && !stat.is_tick;
		cmd.scan = (state_q == S_SCAN);
		cmd.dispatch = (state_q == S_DISP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_fire) state_q <= S_DEC;
				S_DEC: state_q <= stat.is_tick ? S_SCAN : S_OUT;
				S_SCAN: if (stat.scan_last) state_q <= S_DISP;
				S_DISP: state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
